// ----- hdl/psf_pkg.sv -----
`default_nettype none
// ============================================================================
// psf_pkg
// Shared types and codes of the pair sum finder.
// ============================================================================
package psf_pkg;

    // Fixed widths of the result fields
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned INDEX_OUT_W = 10;

    // Slot tag width; tag zero marks a slot as empty after a clearing pass
    localparam int unsigned EPOCH_BITS  = 8;

    // Configuration register indexes
    localparam int unsigned REG_TARGET_SUM = 0;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_NONE     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [INDEX_OUT_W-1:0]   earlier;
        logic [INDEX_OUT_W-1:0]   later;
    } result_t;

    typedef struct packed {
        logic first;
        logic last;
        logic comp_ok;
    } cmd_flags_t;

    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_LOOKUP,
        BK_INSERT
    } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/psf_queue.sv -----
`default_nettype none
// ============================================================================
// psf_queue
// Small register FIFO that decouples two sides of the block.
// ============================================================================
module psf_queue #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/psf_front.sv -----
`default_nettype none
// ============================================================================
// psf_front
// Accepts elements, forms the exact complement and classifies the item.
// ============================================================================
module psf_front
    import psf_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32,
    localparam int unsigned CMD_W     = 2 * VALUE_BITS + $bits(cmd_flags_t)
) (
    input  wire logic                  push,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  first,
    input  wire logic                  last,
    input  wire logic [VALUE_BITS-1:0] target_sum,
    input  wire logic                  hold,
    input  wire logic                  cmd_full,
    output logic                       full,
    output logic                       cmd_push,
    output logic [CMD_W-1:0]           cmd
);
    logic [VALUE_BITS:0] a_ext;
    logic [VALUE_BITS:0] b_ext;
    logic [VALUE_BITS:0] diff;
    cmd_flags_t          flags;

    assign full     = cmd_full || hold;
    assign cmd_push = push && !full;

    // Difference in one extra bit is exact; it fits when the top two bits agree
    assign a_ext = {target_sum[VALUE_BITS-1], target_sum};
    assign b_ext = {value[VALUE_BITS-1], value};
    assign diff  = a_ext - b_ext;

    assign flags.first   = first;
    assign flags.last    = last;
    assign flags.comp_ok = (diff[VALUE_BITS] == diff[VALUE_BITS-1]);

    assign cmd = {flags, diff[VALUE_BITS-1:0], value};

endmodule
`default_nettype wire

// ----- hdl/psf_back.sv -----
`default_nettype none
// ============================================================================
// psf_back
// Probe sequencer over the open-addressed slot memory: lookup, insert,
// result generation and the clearing pass.
// ============================================================================
module psf_back
    import psf_pkg::*;
#(
    parameter int unsigned VALUE_BITS  = 32,
    parameter int unsigned MAX_ITEMS   = 1024,
    parameter int unsigned TABLE_SLOTS = 2048,
    localparam int unsigned CMD_W      = 2 * VALUE_BITS + $bits(cmd_flags_t)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic [CMD_W-1:0] cmd,
    output logic                  cmd_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output result_t               res,
    output logic                  sweeping
);
    localparam int unsigned AW    = $clog2(TABLE_SLOTS);
    localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [AW-1:0]         LAST_POS   = AW'(TABLE_SLOTS - 1);
    localparam logic [AW:0]           SLOTS_EXT  = (AW + 1)'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]      ITEM_LIMIT = CNT_W'(MAX_ITEMS);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_INIT = EPOCH_BITS'(1);

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [VALUE_BITS-1:0] key;
        logic [IDX_W-1:0]      idx;
    } slot_t;

    function automatic logic [AW-1:0] slot_of(input logic [VALUE_BITS-1:0] key);
        logic [VALUE_BITS+AW-1:0] kx;
        logic [AW:0]              h;
        kx = {{AW{1'b0}}, key};
        h  = {1'b0, kx[AW-1:0]};
        if (h >= SLOTS_EXT)
        begin
            h = h - SLOTS_EXT;
        end
        return h[AW-1:0];
    endfunction

    function automatic logic [INDEX_OUT_W-1:0] out_index(input logic [IDX_W-1:0] i);
        logic [IDX_W+INDEX_OUT_W-1:0] ext;
        ext = {{INDEX_OUT_W{1'b0}}, i};
        return ext[INDEX_OUT_W-1:0];
    endfunction

    slot_t mem [TABLE_SLOTS];
    slot_t rd_reg;

    back_state_t           state_reg, state_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg, done_next;
    logic [AW-1:0]         sweep_reg, sweep_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         steps_reg, steps_next;
    logic [VALUE_BITS-1:0] comp_reg, comp_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  last_reg, last_next;

    cmd_flags_t            fl;
    logic [VALUE_BITS-1:0] cmd_comp;
    logic [VALUE_BITS-1:0] cmd_val;
    logic [CNT_W-1:0]      eff_count;
    logic                  eff_done;
    logic                  tag_ok;
    logic [AW-1:0]         pos_inc;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    slot_t                 mem_wdata;

    assign fl       = cmd[CMD_W-1 -: $bits(cmd_flags_t)];
    assign cmd_comp = cmd[2*VALUE_BITS-1:VALUE_BITS];
    assign cmd_val  = cmd[VALUE_BITS-1:0];
    assign tag_ok   = (rd_reg.tag == epoch_reg);
    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign sweeping = (state_reg == BK_SWEEP);

    always_comb
    begin
        state_next  = state_reg;
        epoch_next  = epoch_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        sweep_next  = sweep_reg;
        pos_next    = pos_reg;
        steps_next  = steps_reg;
        comp_next   = comp_reg;
        val_next    = val_reg;
        last_next   = last_reg;
        eff_count   = count_reg;
        eff_done    = done_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res.status  = ST_NONE;
        res.earlier = '0;
        res.later   = '0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = '0;

        unique case (state_reg)
            BK_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_POS)
                begin
                    epoch_next = EPOCH_INIT;
                    state_next = BK_IDLE;
                end
            end

            BK_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    // Out of fresh tags: clear the memory, keep the item waiting
                    if (fl.first && epoch_reg == EPOCH_LAST)
                    begin
                        sweep_next = '0;
                        state_next = BK_SWEEP;
                    end
                    else
                    begin
                        cmd_pop   = 1'b1;
                        comp_next = cmd_comp;
                        val_next  = cmd_val;
                        last_next = fl.last;
                        if (fl.first)
                        begin
                            epoch_next = epoch_reg + 1'b1;
                            eff_count  = '0;
                            eff_done   = 1'b0;
                        end
                        count_next = eff_count;
                        done_next  = eff_done;
                        priority if (eff_done)
                        begin
                            // Drop the rest of a finished array
                        end
                        else if (eff_count >= ITEM_LIMIT)
                        begin
                            res_push   = 1'b1;
                            res.status = ST_OVERFLOW;
                            done_next  = 1'b1;
                        end
                        else if (fl.comp_ok)
                        begin
                            pos_next   = slot_of(cmd_comp);
                            steps_next = '0;
                            state_next = BK_LOOKUP;
                        end
                        else if (fl.last)
                        begin
                            res_push   = 1'b1;
                            res.status = ST_NONE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            pos_next   = slot_of(cmd_val);
                            steps_next = '0;
                            state_next = BK_INSERT;
                        end
                    end
                end
            end

            BK_LOOKUP:
            begin
                priority if (tag_ok && rd_reg.key == comp_reg)
                begin
                    res_push    = 1'b1;
                    res.status  = ST_FOUND;
                    res.earlier = out_index(rd_reg.idx);
                    res.later   = out_index(count_reg[IDX_W-1:0]);
                    done_next   = 1'b1;
                    state_next  = BK_IDLE;
                end
                else if (!tag_ok || steps_reg == LAST_POS)
                begin
                    if (last_reg)
                    begin
                        res_push   = 1'b1;
                        res.status = ST_NONE;
                        done_next  = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        pos_next   = slot_of(val_reg);
                        steps_next = '0;
                        state_next = BK_INSERT;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end

            BK_INSERT:
            begin
                priority if (!tag_ok || rd_reg.key == val_reg)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = pos_reg;
                    mem_wdata.tag = epoch_reg;
                    mem_wdata.key = val_reg;
                    mem_wdata.idx = count_reg[IDX_W-1:0];
                    count_next    = count_reg + 1'b1;
                    state_next    = BK_IDLE;
                end
                else if (steps_reg == LAST_POS)
                begin
                    res_push   = 1'b1;
                    res.status = ST_OVERFLOW;
                    done_next  = 1'b1;
                    state_next = BK_IDLE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = BK_SWEEP;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_SWEEP;
            epoch_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        steps_reg <= steps_next;
        comp_reg  <= comp_next;
        val_reg   <= val_next;
        last_reg  <= last_next;
    end

    // Slot memory: one write port, one registered read port that follows
    // the next probe position
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[pos_next];
    end

endmodule
`default_nettype wire

// ----- hdl/pair_sum_finder_core.sv -----
`default_nettype none
// ============================================================================
// pair_sum_finder_core
// Two-sum search over a streamed array with an open-addressed hash table.
// ============================================================================
// Verdicts: one that needs no probe (count overflow, a last element whose
//   complement does not fit) is pushed from the idle state; a hit is pushed
//   from the lookup state once a probe of the slot memory matches.
// Flow: the back part takes a queued item only in its idle state; later
//   items wait in the command queue meanwhile; probing sets the pace.
// Reset: asynchronous, active low; a clearing pass over all TABLE_SLOTS slots
//   follows, with full high; it runs again at the 255th new array, then every
//   254th.
// ============================================================================
module pair_sum_finder_core
    import psf_pkg::*;
#(
    parameter int unsigned MAX_ITEMS   = 1024,
    parameter int unsigned TABLE_SLOTS = 2048,
    parameter int unsigned VALUE_BITS  = 32,
    localparam int unsigned DATA_W     = (VALUE_BITS > 32) ? 64 : 32,
    localparam int unsigned ADDR_LSB   = (VALUE_BITS > 32) ? 3 : 2,
    localparam int unsigned ADDR_W     = ADDR_LSB + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // element side
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                         first,
    input  wire logic                         last,
    // result side
    output logic                              empty,
    input  wire logic                         pop,
    output logic [STATUS_W-1:0]               status,
    output logic [INDEX_OUT_W-1:0]            earlier_index,
    output logic [INDEX_OUT_W-1:0]            later_index,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_W-1:0]            paddr,
    input  wire logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]                 prdata,
    output logic                              pready
);
    localparam int unsigned CMD_W = 2 * VALUE_BITS + $bits(cmd_flags_t);
    localparam int unsigned RES_W = $bits(result_t);

    // ------------------------------------------------------------------
    // Configuration: target_sum is the only register. Writes land on the
    // access phase; reads return the held value, unmapped addresses read 0.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0] target_sum_reg;
    logic                  cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[ADDR_W-1:ADDR_LSB] == 1'(REG_TARGET_SUM));
    assign prdata  = cfg_hit ? DATA_W'(target_sum_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            target_sum_reg <= pwdata[VALUE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Front: form the complement at acceptance and queue the item.
    // Hold off new items while the slot memory is being cleared.
    // ------------------------------------------------------------------
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic [CMD_W-1:0] cmd_head;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             sweeping;

    psf_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .push       (push),
        .value      (value),
        .first      (first),
        .last       (last),
        .target_sum (target_sum_reg),
        .hold       (sweeping),
        .cmd_full   (cmd_full),
        .full       (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    psf_queue #(
        .W     (CMD_W),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty)
    );

    // ------------------------------------------------------------------
    // Back: probe sequencer. It starts an item only when the result queue
    // has room, so a result it produces always finds a free entry.
    // ------------------------------------------------------------------
    logic    res_push;
    result_t res_in;
    result_t res_head;
    logic    res_full;

    psf_back #(
        .VALUE_BITS  (VALUE_BITS),
        .MAX_ITEMS   (MAX_ITEMS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .sweeping  (sweeping)
    );

    // ------------------------------------------------------------------
    // Result queue: finished items wait here until popped, while the back
    // part goes on with the next element.
    // ------------------------------------------------------------------
    logic [RES_W-1:0] res_head_bits;

    psf_queue #(
        .W     (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head_bits),
        .empty (empty)
    );

    assign res_head      = result_t'(res_head_bits);
    assign status        = res_head.status;
    assign earlier_index = res_head.earlier;
    assign later_index   = res_head.later;

endmodule
`default_nettype wire

// ----- hdl/psf_checker.sv -----
`default_nettype none
// ============================================================================
// psf_checker
// Port-level checks of the pair sum finder, bound to the top level.
// ============================================================================
module psf_checker
    import psf_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 1024
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [STATUS_W-1:0]    status,
    input wire logic [INDEX_OUT_W-1:0] earlier_index,
    input wire logic [INDEX_OUT_W-1:0] later_index
);

    // Only a found pair carries indices
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_FOUND) |-> (earlier_index == '0 && later_index == '0))
        else $error("psf: indices nonzero on a result without a pair");

    // With MAX_ITEMS up to 1024 the stored partner always comes before the current element
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FOUND && MAX_ITEMS <= 1024)
            |-> (earlier_index < later_index))
        else $error("psf: found pair out of order");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status)
            && $stable(earlier_index) && $stable(later_index)))
        else $error("psf: waiting result changed before pop");

endmodule

bind pair_sum_finder_core psf_checker #(
    .MAX_ITEMS (MAX_ITEMS)
) u_psf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .earlier_index (earlier_index),
    .later_index   (later_index)
);
`default_nettype wire

// ----- bench/tb_pair_sum_finder_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_pair_sum_finder_core
// Self-checking bench for the streamed two-sum search block: a queue-fed
// driver offers array elements, a scoreboard model predicts each verdict,
// and a monitor pops results under random stalls and compares every field.
// ============================================================================
module tb_pair_sum_finder_core;
    import psf_pkg::*;

    // Block configuration, kept at the defaults of the top level
    localparam int unsigned MAX_ITEMS   = 1024;
    localparam int unsigned TABLE_SLOTS = 2048;
    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = 3;

    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    // Quiet cycles after the last verdict before touching the register
    localparam int SETTLE_CYCLES = 64;
    // Receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 600;
    // Run limit, far above the slowest legal run including clearing passes
    localparam int LIMIT_CYCLES  = 600000;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         first;
        logic                         last;
    } element_t;

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                         clk     = 1'b0;
    logic                         rst_n   = 1'b0;
    logic                         push    = 1'b0;
    logic signed [VALUE_BITS-1:0] value   = '0;
    logic                         first   = 1'b0;
    logic                         last    = 1'b0;
    logic                         pop     = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [ADDR_W-1:0]            paddr   = '0;
    logic [DATA_W-1:0]            pwdata  = '0;

    logic                         full;
    logic                         empty;
    logic [STATUS_W-1:0]          status;
    logic [INDEX_OUT_W-1:0]       earlier_index;
    logic [INDEX_OUT_W-1:0]       later_index;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;

    pair_sum_finder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .value         (value),
        .first         (first),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .earlier_index (earlier_index),
        .later_index   (later_index),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    element_t elem_q[$];        // elements waiting to be offered
    result_t  verdict_q[$];     // verdicts owed by the block, oldest first

    // Shadow of the block: value-to-index map, running index, done flag
    int                           seen_index[int];
    int unsigned                  elem_count   = 0;
    bit                           search_done  = 1'b0;
    logic signed [VALUE_BITS-1:0] target_copy  = '0;

    int unsigned sender_idle_pct = 0;
    int unsigned rx_stall_pct    = 0;
    int unsigned hold_seq        = 0;
    int unsigned hold_served     = 0;
    int unsigned hold_left       = 0;
    int unsigned cycle_count     = 0;
    int unsigned errors          = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Count cycles and abort a run that hangs on some handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Verdict prediction: one call per accepted element
    // ------------------------------------------------------------------------
    task automatic search_pair(input element_t e, output bit produced,
                               output result_t verdict);
        longint comp;
        int     key;
        produced = 1'b0;
        verdict  = '0;
        // A first mark clears the map before the element is looked at
        if (e.first)
        begin
            seen_index.delete();
            elem_count  = 0;
            search_done = 1'b0;
        end
        // Drop everything after the array has already been answered
        if (search_done)
            return;
        if (elem_count >= MAX_ITEMS)
        begin
            search_done    = 1'b1;
            produced       = 1'b1;
            verdict.status = ST_OVERFLOW;
            return;
        end
        // Exact complement; one outside the value range can never match
        comp = longint'(target_copy) - longint'(e.value);
        if (comp >= VALUE_MIN && comp <= VALUE_MAX && seen_index.exists(int'(comp)))
        begin
            search_done     = 1'b1;
            produced        = 1'b1;
            verdict.status  = ST_FOUND;
            verdict.earlier = INDEX_OUT_W'(seen_index[int'(comp)]);
            verdict.later   = INDEX_OUT_W'(elem_count);
            return;
        end
        // A miss on the final element ends the array without storing it
        if (e.last)
        begin
            search_done    = 1'b1;
            produced       = 1'b1;
            verdict.status = ST_NONE;
            return;
        end
        key = int'(e.value);
        // Table full: a new value with every slot taken
        if (!seen_index.exists(key) && seen_index.num() >= TABLE_SLOTS)
        begin
            search_done    = 1'b1;
            produced       = 1'b1;
            verdict.status = ST_OVERFLOW;
            return;
        end
        // Repeated values keep their newest index
        seen_index[key] = elem_count;
        elem_count      = elem_count + 1;
    endtask

    // ------------------------------------------------------------------------
    // Element driver: offer the queue head, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : element_driver
        bit      produced;
        result_t verdict;
        bit      offer;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            // Accepted at this edge: predict and retire the head
            if (push && !full)
            begin
                search_pair(elem_q[0], produced, verdict);
                if (produced)
                    verdict_q.push_back(verdict);
                void'(elem_q.pop_front());
            end
            // Hold a refused offer; otherwise idle at random
            if (push && full)
                offer = 1'b1;
            else
                offer = (elem_q.size() > 0) && ($urandom_range(99) >= sender_idle_pct);
            if (offer)
            begin
                push  <= 1'b1;
                value <= elem_q[0].value;
                first <= elem_q[0].first;
                last  <= elem_q[0].last;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: counted here, requested by the stimulus
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_seq != hold_served)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_seq;
        end
    end

    // ------------------------------------------------------------------------
    // Verdict monitor: pop at random, compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_monitor
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
            begin
                errors = errors + 1;
                $display({"%0t: unexpected verdict: expected none, ",
                          "actual status %0d earlier %0d later %0d"},
                         $realtime, status, earlier_index, later_index);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (status !== want.status)
                begin
                    errors = errors + 1;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, want.status, status);
                end
                if (earlier_index !== want.earlier)
                begin
                    errors = errors + 1;
                    $display("%0t: earlier_index mismatch: expected %0d, actual %0d",
                             $realtime, want.earlier, earlier_index);
                end
                if (later_index !== want.later)
                begin
                    errors = errors + 1;
                    $display("%0t: later_index mismatch: expected %0d, actual %0d",
                             $realtime, want.later, later_index);
                end
            end
        end
        if (!rst_n || hold_left > 0)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic offer_element(input logic signed [VALUE_BITS-1:0] v,
                                 input bit is_first, input bit is_last);
        element_t e;
        e.value = v;
        e.first = is_first;
        e.last  = is_last;
        elem_q.push_back(e);
    endtask

    // Mix of small values, planted complements, extremes and full-range noise
    function automatic logic signed [VALUE_BITS-1:0] pick_value(
            input logic signed [VALUE_BITS-1:0] partner, input bit has_partner);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return $urandom_range(16) - 8;
        if (roll < 55 && has_partner)
            return target_copy - partner;
        if (roll < 70)
        begin
            case ($urandom_range(5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return target_copy;
                default: return target_copy >>> 1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_array(input int len, input bit with_first, input bit with_last);
        logic signed [VALUE_BITS-1:0] vals[$];
        logic signed [VALUE_BITS-1:0] partner;
        logic signed [VALUE_BITS-1:0] v;
        for (int i = 0; i < len; i++)
        begin
            partner = (vals.size() > 0) ? vals[$urandom_range(vals.size() - 1)] : '0;
            v = pick_value(partner, vals.size() > 0);
            vals.push_back(v);
            offer_element(v, with_first && (i == 0), with_last && (i == len - 1));
        end
    endtask

    // Mostly complete arrays with random content; the rest open or stray
    task automatic random_traffic(input int n_items);
        int sent;
        int roll;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
            if (roll < 82)
                queue_array(len, 1'b1, 1'b1);
            else if (roll < 90)
                queue_array(len, 1'b1, 1'b0);
            else if (roll < 96)
            begin
                len = $urandom_range(3, 1);
                queue_array(len, 1'b0, 1'b0);
            end
            else
                queue_array(len, 1'b0, 1'b1);
            sent = sent + len;
        end
    endtask

    // Close with a lone first-and-last element, which always answers, then
    // wait until every verdict is in and the pipeline has gone quiet
    task automatic close_and_settle();
        offer_element($urandom, 1'b1, 1'b1);
        do
            @(posedge clk);
        while (elem_q.size() != 0 || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write (setup + access) followed by a read-back check
    task automatic write_target(input logic signed [VALUE_BITS-1:0] t);
        logic [DATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(REG_TARGET_SUM * 4);
        pwdata  <= t;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        target_copy = t;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== t)
        begin
            errors = errors + 1;
            $display("%0t: target_sum read-back mismatch: expected %0d, actual %0d",
                     $realtime, t, $signed(got));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold reset at the start; the clearing pass shows up as full
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset target of zero
        // No first ever: the opening elements already form array zero
        offer_element(32'sd5, 1'b0, 1'b0);
        offer_element(-32'sd5, 1'b0, 1'b0);
        // Ignored once the array is answered
        offer_element(32'sd7, 1'b0, 1'b0);
        // Complement of the most negative value does not fit
        offer_element(32'h8000_0000, 1'b1, 1'b1);
        // Extreme pair summing to zero
        offer_element(32'h7FFF_FFFF, 1'b1, 1'b0);
        offer_element(32'h8000_0001, 1'b0, 1'b1);
        // Repeated value keeps its newest index
        offer_element(32'sd3, 1'b1, 1'b0);
        offer_element(32'sd3, 1'b0, 1'b0);
        offer_element(32'sd3, 1'b0, 1'b0);
        offer_element(-32'sd3, 1'b0, 1'b1);
        // Element that is its own complement pairs with an earlier copy
        offer_element(32'sd0, 1'b1, 1'b0);
        offer_element(32'sd0, 1'b0, 1'b0);
        // Miss on the last element, then a stray element that is dropped
        offer_element(32'sd1, 1'b1, 1'b0);
        offer_element(32'sd2, 1'b0, 1'b1);
        offer_element(32'sd9, 1'b0, 1'b0);
        // Array left open and restarted by a new first
        offer_element(32'sd10, 1'b1, 1'b0);
        offer_element(32'sd20, 1'b0, 1'b0);
        offer_element(32'sd30, 1'b1, 1'b1);
        close_and_settle();

        // Largest target: overflowing complement on negative values
        write_target(32'sh7FFF_FFFF);
        offer_element(32'sd0, 1'b1, 1'b0);
        offer_element(32'h7FFF_FFFF, 1'b0, 1'b1);
        offer_element(32'hFFFF_FFFF, 1'b1, 1'b1);
        close_and_settle();

        // Smallest target: overflowing complement on positive values
        write_target(32'sh8000_0000);
        offer_element(32'hFFFF_FFFF, 1'b1, 1'b0);
        offer_element(32'sd1, 1'b0, 1'b0);
        offer_element(32'sd0, 1'b0, 1'b0);
        offer_element(32'h8000_0000, 1'b0, 1'b1);
        close_and_settle();

        // Random phases, one register setting and one idling mix each
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin sender_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            case (ph)
                0: write_target($urandom_range(16) - 8);
                1: write_target($urandom);
                2: write_target(32'hFFFF_FFFF);
                default: write_target(32'sh7FFF_FFFF - $urandom_range(3));
            endcase
            random_traffic(125);
            close_and_settle();
        end

        // Back-pressure: stop popping for a long stretch while the sender
        // keeps offering answered arrays, so the block fills and stalls push
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        write_target($urandom);
        @(posedge clk);
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 3 == 0)
                queue_array(2, 1'b1, 1'b1);
            else
                offer_element($urandom, 1'b1, 1'b1);
        end
        close_and_settle();

        // Too many elements: odd target and even values never pair
        sender_idle_pct = 16;
        rx_stall_pct    = 16;
        write_target($urandom | 32'h1);
        for (int i = 0; i <= MAX_ITEMS; i++)
            offer_element($urandom & 32'hFFFF_FFFE, i == 0, 1'b0);
        // Dropped after the overflow verdict
        offer_element(32'sd4, 1'b0, 1'b0);
        offer_element(32'sd6, 1'b0, 1'b1);
        close_and_settle();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
